// ===== rtl/fbfla_pkg.sv =====
// Shared types and constants for the fixed-block free-list allocator.
// No dependencies; imported by fbfla_offset and fixed_block_free_list_allocator.
`default_nettype none

package fbfla_pkg;

	localparam int MAX_BLOCKS  = 256;
	localparam int HANDLE_W    = 8;
	localparam int COUNT_W     = 9;
	localparam int WORD_BYTES  = 8;
	localparam int WORD_SHIFT  = 3;
	localparam int PAYLOAD_W   = 13;
	localparam int STRIDE_W    = 14;
	localparam int OFFSET_W    = 20;
	localparam int STATUS_W    = 2;
	localparam int CFG_INDEX_W = 1;

	// control area (two words) plus the block's own header word
	localparam int PAYLOAD_BASE = 3 * WORD_BYTES;

	// output tdata: handle_out, payload_offset, free_blocks, padded to bytes
	localparam int M_TDATA_FIELDS_W = HANDLE_W + OFFSET_W + COUNT_W;
	localparam int M_TDATA_W        = ((M_TDATA_FIELDS_W + 7) / 8) * 8;

	localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET    = PAYLOAD_W'(8);
	localparam logic [COUNT_W-1:0]   BLOCKS_RESET     = COUNT_W'(MAX_BLOCKS);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PAYLOAD_BYTES = 1'b0,
		REG_BLOCKS_IN_USE = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/fbfla_offset.sv =====
// Payload byte offset of a block: PAYLOAD_BASE + handle * stride, wrapped to 20 bits.
// Depends on fbfla_pkg.
`default_nettype none

module fbfla_offset (
	input  wire logic [fbfla_pkg::HANDLE_W-1:0] handle,
	input  wire logic [fbfla_pkg::STRIDE_W-1:0] stride,
	output logic [fbfla_pkg::OFFSET_W-1:0]      offset
);
	import fbfla_pkg::*;

	logic [HANDLE_W+STRIDE_W-1:0] product;

	always_comb begin
		product = (HANDLE_W+STRIDE_W)'(handle) * (HANDLE_W+STRIDE_W)'(stride);
		offset  = product[OFFSET_W-1:0] + OFFSET_W'(PAYLOAD_BASE);
	end

endmodule

`default_nettype wire

// ===== rtl/fixed_block_free_list_allocator.sv =====
// Top level of the fixed-block free-list allocator: list state, link memory, result register.
// Depends on fbfla_pkg and fbfla_offset.
//
// Usage:
//   Requests enter on the s_axis channel: tuser[0] is the command (0 allocate,
//   1 free), tdata[7:0] the handle to free. Every request gives exactly one result
//   on m_axis: tuser[1:0] status (0 ok, 1 pool empty, 2 bad free), tdata holds
//   handle_out, payload_offset and the free block count after the request.
//   Handles are granted LIFO: freed blocks first, most recent on top, then blocks
//   never yet granted in ascending order starting from 0.
//   The result is registered at the edge that takes the request. Throughput is
//   one request per cycle while the receiver takes results; the successor of the
//   list head is kept in a register refilled from the link memory's registered
//   read port, so back-to-back pops do not stall.
//   If the receiver stalls, the result register holds and s_axis_tready drops
//   until the held result is taken; a new request is taken in the same cycle the
//   held result leaves.
//   The cfg channel (always ready) writes payload_bytes (index 0) or
//   blocks_in_use (index 1); any write re-initializes the pool. Write only while
//   idle. Reset gives payload_bytes 8, 256 blocks, all free; no clearing pass.
`default_nettype none

module fixed_block_free_list_allocator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// request channel
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  wire logic [fbfla_pkg::HANDLE_W-1:0]       s_axis_tdata,  // [7:0] block_handle
	input  wire logic [0:0]                           s_axis_tuser,  // [0] command
	// result channel
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// [7:0] handle_out, [27:8] payload_offset, [36:28] free_blocks, [39:37] zero
	output logic [fbfla_pkg::M_TDATA_W-1:0]           m_axis_tdata,
	output logic [fbfla_pkg::STATUS_W-1:0]            m_axis_tuser,  // [1:0] status
	// configuration write channel
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [fbfla_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [fbfla_pkg::PAYLOAD_W-1:0]      cfg_data
);
	import fbfla_pkg::*;

	function automatic logic [STRIDE_W-1:0] stride_of(input logic [PAYLOAD_W-1:0] pbytes);
		logic [STRIDE_W-1:0] raw;
		raw = STRIDE_W'(pbytes) + STRIDE_W'(2 * WORD_BYTES - 1);
		return {raw[STRIDE_W-1:WORD_SHIFT], WORD_SHIFT'(0)};
	endfunction

	// configuration and pool state
	logic [STRIDE_W-1:0]   stride_q;
	logic [COUNT_W-1:0]    nblk_q;
	logic [HANDLE_W-1:0]   list_head_q;
	logic [HANDLE_W-1:0]   head_link_q;   // link_mem[list_head_q], valid when list nonempty
	logic [COUNT_W-1:0]    untouched_q;
	logic [COUNT_W-1:0]    free_cnt_q;
	logic [MAX_BLOCKS-1:0] taken_q;
	logic [HANDLE_W-1:0]   link_mem [MAX_BLOCKS];

	// result register
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic [OFFSET_W-1:0]   out_offset_q;
	logic [COUNT_W-1:0]    out_free_q;

	logic                  accept;
	logic                  cfg_write;
	cmd_t                  cmd;
	logic [HANDLE_W-1:0]   req_handle;
	logic [COUNT_W-1:0]    fresh_cnt;
	logic                  linked_avail;
	logic                  pool_empty;
	logic                  bad_free;
	logic                  pop;
	logic                  take_fresh;
	logic                  free_ok;
	logic [HANDLE_W-1:0]   alloc_handle;
	logic [HANDLE_W-1:0]   sel_handle;
	logic [OFFSET_W-1:0]   sel_offset;
	logic [COUNT_W-1:0]    cfg_nblk;
	status_t               res_status;
	logic [HANDLE_W-1:0]   res_handle;
	logic [OFFSET_W-1:0]   res_offset;
	logic [COUNT_W-1:0]    res_free;

	assign cfg_ready     = 1'b1;
	assign cfg_write     = cfg_valid && cfg_ready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign cmd        = cmd_t'(s_axis_tuser[0]);
	assign req_handle = s_axis_tdata;

	assign cfg_nblk = (cfg_data[COUNT_W-1:0] > COUNT_W'(MAX_BLOCKS)) ?
		COUNT_W'(MAX_BLOCKS) : cfg_data[COUNT_W-1:0];

	fbfla_offset u_offset (
		.handle (sel_handle),
		.stride (stride_q),
		.offset (sel_offset)
	);

	always_comb begin
		// blocks from the untouched mark upward are free but not on the linked stack
		fresh_cnt    = nblk_q - untouched_q;
		linked_avail = free_cnt_q > fresh_cnt;
		pool_empty   = free_cnt_q == '0;
		alloc_handle = linked_avail ? list_head_q : untouched_q[HANDLE_W-1:0];
		bad_free     = ({1'b0, req_handle} >= nblk_q) || !taken_q[req_handle];
		sel_handle   = (cmd == CMD_ALLOC) ? alloc_handle : req_handle;

		pop        = 1'b0;
		take_fresh = 1'b0;
		free_ok    = 1'b0;
		res_status = ST_OK;
		res_handle = sel_handle;
		res_offset = sel_offset;
		res_free   = free_cnt_q;

		unique case (cmd)
			CMD_ALLOC: begin
				if (pool_empty) begin
					res_status = ST_EMPTY;
					res_handle = '0;
					res_offset = '0;
				end else begin
					pop        = accept && linked_avail;
					take_fresh = accept && !linked_avail;
					res_free   = free_cnt_q - COUNT_W'(1);
				end
			end
			CMD_FREE: begin
				if (bad_free) begin
					res_status = ST_BAD_FREE;
					res_offset = '0;
				end else begin
					free_ok  = accept;
					res_free = free_cnt_q + COUNT_W'(1);
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	// pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q    <= stride_of(PAYLOAD_RESET);
			nblk_q      <= BLOCKS_RESET;
			list_head_q <= '0;
			untouched_q <= '0;
			free_cnt_q  <= BLOCKS_RESET;
			taken_q     <= '0;
		end else if (cfg_write) begin
			list_head_q <= '0;
			untouched_q <= '0;
			taken_q     <= '0;
			unique case (cfg_reg_t'(cfg_index))
				REG_PAYLOAD_BYTES: begin
					stride_q   <= stride_of(cfg_data);
					free_cnt_q <= nblk_q;
				end
				REG_BLOCKS_IN_USE: begin
					nblk_q     <= cfg_nblk;
					free_cnt_q <= cfg_nblk;
				end
				default: begin
					free_cnt_q <= nblk_q;
				end
			endcase
		end else begin
			if (pop || take_fresh || free_ok) begin
				free_cnt_q <= res_free;
			end
			if (pop) begin
				list_head_q <= head_link_q;
			end else if (free_ok) begin
				list_head_q <= req_handle;
			end
			if (take_fresh) begin
				untouched_q <= untouched_q + COUNT_W'(1);
			end
			if (pop || take_fresh) begin
				taken_q[alloc_handle] <= 1'b1;
			end else if (free_ok) begin
				taken_q[req_handle] <= 1'b0;
			end
		end
	end

	// link memory: one write port, one registered read port feeding head_link_q.
	// On a push the new head's link is the old head, so no read is needed.
	always_ff @(posedge clk) begin
		if (free_ok && !cfg_write) begin
			link_mem[req_handle] <= list_head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !cfg_write) begin
			head_link_q <= link_mem[head_link_q];
		end else if (free_ok && !cfg_write) begin
			head_link_q <= list_head_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= res_status;
			out_handle_q <= res_handle;
			out_offset_q <= res_offset;
			out_free_q   <= res_free;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {(M_TDATA_W - M_TDATA_FIELDS_W)'(0), out_free_q, out_offset_q,
		out_handle_q};

	// every block is either taken or counted free
	a_count_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(taken_q) + int'(free_cnt_q) == int'(nblk_q))
		else $error("taken flags and free counter disagree");

	a_untouched_range: assert property (@(posedge clk) disable iff (!arst_n)
		untouched_q <= nblk_q)
		else $error("untouched mark beyond pool size");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == ST_EMPTY |->
			out_handle_q == '0 && out_offset_q == '0 && out_free_q == '0)
		else $error("pool-empty result carries a block");

	a_pop_granted: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !cfg_write |=> taken_q[$past(list_head_q)])
		else $error("popped block not marked taken");

endmodule

`default_nettype wire
